// ===== hdl/dsd_pkg.sv =====
// Shared types, constants and helper functions for the decimal digit driver.
// No dependencies; every other file in hdl/ imports this package.
package dsd_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_ZERO_THR = 2'd0,
    CFG_TOP_THR  = 2'd1,
    CFG_TOP_VAL  = 2'd2,
    CFG_UNUSED   = 2'd3
  } cfg_idx_t;

  // Live configuration handed to the clamp stages
  typedef struct packed {
    logic [15:0] zero_thr;
    logic [15:0] top_thr;
    logic [15:0] top_val;
  } cfg_t;

  localparam logic [15:0] ZeroThrReset = 16'd16;
  localparam logic [15:0] TopThrReset  = 16'd1005;
  localparam logic [15:0] TopValReset  = 16'd1023;
  localparam logic [15:0] MaxShown     = 16'd9999;

  // Bits of a value that fits in four decimal digits
  localparam int unsigned ValW  = 14;
  // Bits converted in each of the two BCD stages
  localparam int unsigned HalfW = 7;

  // Segment pattern, bit0 A through bit6 G
  function automatic logic [6:0] seg_encode(input logic [3:0] d);
    logic [6:0] s;
    unique case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h67;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

  // One shift-and-add-3 step: correct each BCD nibble, then shift in a bit
  function automatic logic [15:0] dd_step(input logic [15:0] bcd, input logic b);
    logic [15:0] adj;
    adj = bcd;
    for (int n = 0; n < 4; n++) begin
      if (bcd[4*n +: 4] >= 4'd5) begin
        adj[4*n +: 4] = bcd[4*n +: 4] + 4'd3;
      end
    end
    return {adj[14:0], b};
  endfunction

endpackage

// ===== hdl/dsd_clamp.sv =====
// Two pipeline stages: zero clamp, then top clamp with range drop.
// Depends on dsd_pkg.
module dsd_clamp import dsd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              in_vld,
  output logic              in_rdy,
  input  logic [15:0]       in_value,
  output logic              out_vld,
  input  logic              out_rdy,
  output logic [ValW-1:0]   out_value
);

  logic            s1_vld_r, s1_vld_nxt;
  logic [15:0]     s1_val_r, s1_val_nxt;
  logic            s2_vld_r, s2_vld_nxt;
  logic [ValW-1:0] s2_val_r, s2_val_nxt;
  logic            s1_en, s2_en;
  logic [15:0]     top_clamped;

  // Stage enables: a stage loads when empty or when it drains this cycle
  assign s2_en  = !s2_vld_r || out_rdy;
  assign s1_en  = !s1_vld_r || s2_en;
  assign in_rdy = s1_en;

  // Zero clamp ahead of stage 1
  always_comb begin
    s1_vld_nxt = in_vld;
    s1_val_nxt = (in_value <= cfg.zero_thr) ? 16'd0 : in_value;
  end

  // Top clamp ahead of stage 2; drop values beyond four digits
  always_comb begin
    top_clamped = (s1_val_r >= cfg.top_thr) ? cfg.top_val : s1_val_r;
    s2_vld_nxt  = s1_vld_r && (top_clamped <= MaxShown);
    s2_val_nxt  = top_clamped[ValW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_vld_r <= s1_vld_nxt;
      end
      if (s2_en) begin
        s2_vld_r <= s2_vld_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_val_r <= s1_val_nxt;
    end
    if (s2_en) begin
      s2_val_r <= s2_val_nxt;
    end
  end

  assign out_vld   = s2_vld_r;
  assign out_value = s2_val_r;

endmodule

// ===== hdl/dsd_bcd.sv =====
// Two pipeline stages of binary to BCD conversion, seven bits per stage.
// Depends on dsd_pkg.
module dsd_bcd import dsd_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  output logic            in_rdy,
  input  logic [ValW-1:0] in_value,
  output logic            out_vld,
  input  logic            out_rdy,
  output logic [15:0]     out_bcd
);

  logic             s3_vld_r;
  logic [15:0]      s3_bcd_r, s3_bcd_nxt;
  logic [HalfW-1:0] s3_low_r;
  logic             s4_vld_r;
  logic [15:0]      s4_bcd_r, s4_bcd_nxt;
  logic             s3_en, s4_en;

  assign s4_en  = !s4_vld_r || out_rdy;
  assign s3_en  = !s3_vld_r || s4_en;
  assign in_rdy = s3_en;

  // Convert the upper seven bits
  always_comb begin
    s3_bcd_nxt = 16'd0;
    for (int i = ValW - 1; i >= int'(HalfW); i--) begin
      s3_bcd_nxt = dd_step(s3_bcd_nxt, in_value[i]);
    end
  end

  // Convert the lower seven bits
  always_comb begin
    s4_bcd_nxt = s3_bcd_r;
    for (int i = HalfW - 1; i >= 0; i--) begin
      s4_bcd_nxt = dd_step(s4_bcd_nxt, s3_low_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      if (s3_en) begin
        s3_vld_r <= in_vld;
      end
      if (s4_en) begin
        s4_vld_r <= s3_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en) begin
      s3_bcd_r <= s3_bcd_nxt;
      s3_low_r <= in_value[HalfW-1:0];
    end
    if (s4_en) begin
      s4_bcd_r <= s4_bcd_nxt;
    end
  end

  assign out_vld = s4_vld_r;
  assign out_bcd = s4_bcd_r;

endmodule

// ===== hdl/dsd_serial.sv =====
// Output stage: encodes four BCD digits and sends one digit per cycle.
// Depends on dsd_pkg.
module dsd_serial import dsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  output logic        in_rdy,
  input  logic [15:0] in_bcd,
  output logic        out_strobe,
  output logic [1:0]  out_position,
  output logic [6:0]  out_segments,
  output logic        out_last
);

  logic        active_r, active_nxt;
  logic [27:0] segs_r, segs_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [1:0]  last_pos_r, last_pos_nxt;
  logic        at_last;
  logic [1:0]  top_pos;

  assign at_last = (pos_r == last_pos_r);
  assign in_rdy  = !active_r || at_last;

  // Position of the most significant nonzero digit, ones place if all zero
  always_comb begin
    if (in_bcd[15:12] != 4'd0) begin
      top_pos = 2'd3;
    end else if (in_bcd[11:8] != 4'd0) begin
      top_pos = 2'd2;
    end else if (in_bcd[7:4] != 4'd0) begin
      top_pos = 2'd1;
    end else begin
      top_pos = 2'd0;
    end
  end

  // Load a new run, advance the current one, or go idle
  always_comb begin
    active_nxt   = active_r;
    segs_nxt     = segs_r;
    pos_nxt      = pos_r;
    last_pos_nxt = last_pos_r;
    if (in_rdy && in_vld) begin
      active_nxt   = 1'b1;
      segs_nxt     = {seg_encode(in_bcd[15:12]), seg_encode(in_bcd[11:8]),
                      seg_encode(in_bcd[7:4]),   seg_encode(in_bcd[3:0])};
      pos_nxt      = 2'd0;
      last_pos_nxt = top_pos;
    end else if (active_r) begin
      if (at_last) begin
        active_nxt = 1'b0;
      end else begin
        segs_nxt = {7'd0, segs_r[27:7]};
        pos_nxt  = pos_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pos_r    <= 2'd0;
    end else begin
      active_r <= active_nxt;
      pos_r    <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    segs_r     <= segs_nxt;
    last_pos_r <= last_pos_nxt;
  end

  assign out_strobe   = active_r;
  assign out_position = pos_r;
  assign out_segments = segs_r[6:0];
  assign out_last     = active_r && at_last;

endmodule

// ===== hdl/decimal_seven_segment_digit_driver_core.sv =====
// Top level of the decimal seven-segment digit driver.
// Depends on dsd_pkg, dsd_clamp, dsd_bcd and dsd_serial.
//
// Usage:
//   Input: a value on in_value is transferred at a rising edge with start high
//   and busy low. The value is clamped by the zero and top thresholds, then
//   split into decimal digits with leading zeros dropped.
//   Output: one transfer per shown digit, ones place first, each held for a
//   single cycle with out_strobe high. out_last_digit marks the most
//   significant digit. A clamped value above 9999 produces no transfer.
//   Configuration: cfg_we writes cfg_data into register cfg_index (0 zero
//   threshold, 1 top threshold, 2 top value, 3 ignored); write only when idle.
// Timing:
//   Four pipeline stages (two clamp, two BCD conversion) feed the digit
//   serializer; the first digit of a value reaches the ports once the serializer
//   has taken the value from the last BCD stage, and the following digits in the
//   cycles right after it.
//   The serializer sends one digit per cycle and takes a new value while idle
//   or with its last digit; busy rises when the pipeline backs up behind it.
//   Values that produce no digits pass at one per cycle unless backed up.
// Reset: rst_n clears the pipeline and loads the register reset values
//   16, 1005 and 1023. The receiver cannot stall: results are never held.
module decimal_seven_segment_digit_driver_core import dsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_value,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_strobe,
  output logic [1:0]  out_digit_position,
  output logic [6:0]  out_segments,
  output logic        out_last_digit
);

  cfg_t            cfg_r;
  logic            clamp_rdy;
  logic            clamp_vld;
  logic [ValW-1:0] clamp_value;
  logic            bcd_rdy;
  logic            bcd_vld;
  logic [15:0]     bcd_digits;
  logic            ser_rdy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zero_thr <= ZeroThrReset;
      cfg_r.top_thr  <= TopThrReset;
      cfg_r.top_val  <= TopValReset;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ZERO_THR: cfg_r.zero_thr <= cfg_data;
        CFG_TOP_THR:  cfg_r.top_thr  <= cfg_data;
        CFG_TOP_VAL:  cfg_r.top_val  <= cfg_data;
        CFG_UNUSED:   ;
        default:      ;
      endcase
    end
  end

  assign busy = !clamp_rdy;

  dsd_clamp u_clamp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_vld    (start),
    .in_rdy    (clamp_rdy),
    .in_value  (in_value),
    .out_vld   (clamp_vld),
    .out_rdy   (bcd_rdy),
    .out_value (clamp_value)
  );

  dsd_bcd u_bcd (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (clamp_vld),
    .in_rdy   (bcd_rdy),
    .in_value (clamp_value),
    .out_vld  (bcd_vld),
    .out_rdy  (ser_rdy),
    .out_bcd  (bcd_digits)
  );

  dsd_serial u_serial (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_vld       (bcd_vld),
    .in_rdy       (ser_rdy),
    .in_bcd       (bcd_digits),
    .out_strobe   (out_strobe),
    .out_position (out_digit_position),
    .out_segments (out_segments),
    .out_last     (out_last_digit)
  );

  // A run that has not ended continues in the next cycle
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_digit |=> out_strobe)
    else $error("digit run broke off before its last digit");

  // Positions inside a run step up by one
  a_pos_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_digit |=>
      out_digit_position == $past(out_digit_position) + 2'd1)
    else $error("digit position did not advance by one");

  // A run starting from idle begins at the ones place
  a_run_starts_at_ones: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_strobe) |-> out_digit_position == 2'd0)
    else $error("digit run did not start at the ones place");

  // The serializer only backs up the pipeline while it is sending
  a_stall_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    bcd_vld && !ser_rdy |-> out_strobe && !out_last_digit)
    else $error("pipeline stalled with the serializer free");

endmodule
